>>> hdl/mts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg: shared types and codes of the min tracking stack
// Opcodes, status codes, payload widths and the control records that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned DEPTH_W  = 7;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
	localparam logic [OP_W-1:0] OP_PUSH  = 2'd1;
	localparam logic [OP_W-1:0] OP_POP   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

	// One stored slot: the entry and the minimum of it and all slots below.
	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic signed [DATA_W-1:0] rmin;
	} mts_entry_t;

	// Controller to datapath.
	typedef struct packed {
		logic push;
		logic pop;
		logic load;
	} mts_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic empty;
		logic full;
	} mts_stat_t;

endpackage
`default_nettype wire

>>> hdl/mts_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_req_if: request channel
// Valid/ready channel carrying one stack operation and its value.
// ----------------------------------------------------------------------------
interface mts_req_if
	import mts_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface
`default_nettype wire

>>> hdl/mts_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_rsp_if: response channel
// Valid/ready channel carrying the stack view after one operation.
// ----------------------------------------------------------------------------
interface mts_rsp_if
	import mts_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] top_value;
	logic signed [DATA_W-1:0] min_value;
	logic [DEPTH_W-1:0]       depth;
	logic                     is_empty;
	logic [STATUS_W-1:0]      status;

	modport source (output valid, output top_value, output min_value, output depth,
		output is_empty, output status, input ready);
	modport sink   (input valid, input top_value, input min_value, input depth,
		input is_empty, input status, output ready);
endinterface
`default_nettype wire

>>> hdl/min_tracking_stack.sv
`default_nettype none
// A query or push response is valid in the cycle after the request transfer; a pop
// response follows the S_FILL state, as the new top comes from the registered memory read.
// The controller holds one operation at a time and takes no new request until the
// response has transferred, so any response stall holds the request channel.
// Reset: arst_n clears the entry count and the controller; the slot memory is not
// cleared, and only slots written by a push ever reach the outputs.
// ----------------------------------------------------------------------------
// min_tracking_stack: LIFO stack with minimum tracking
// Push, pop or query per request; each response gives top, minimum, depth,
// an empty flag and a status code.
// ----------------------------------------------------------------------------
module min_tracking_stack
	import mts_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mts_req_if.sink   req,
	mts_rsp_if.source rsp
);

	mts_cmd_t  cmd;
	mts_stat_t stat;

	mts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.stat       (stat),
		.cmd        (cmd),
		.status     (rsp.status)
	);

	mts_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_value (req.value),
		.stat       (stat),
		.top_value  (rsp.top_value),
		.min_value  (rsp.min_value),
		.depth      (rsp.depth),
		.is_empty   (rsp.is_empty)
	);

endmodule
`default_nettype wire

>>> hdl/mts_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_ctrl: stack controller
// Takes one request at a time, issues push, pop and top refill commands to
// the datapath, and holds the response until its transfer.
// ----------------------------------------------------------------------------
module mts_ctrl
	import mts_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	input  wire logic [OP_W-1:0]     req_opcode,
	output logic                     req_ready,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	input  wire mts_stat_t           stat,
	output mts_cmd_t                 cmd,
	output logic [STATUS_W-1:0]      status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FILL,
		S_SEND
	} state_t;

	state_t              state_q;
	logic [STATUS_W-1:0] status_q;
	logic [STATUS_W-1:0] code;
	logic                accept;

	assign accept    = (state_q == S_IDLE) && req_valid;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_SEND);
	assign status    = status_q;

	always_comb begin
		cmd  = '0;
		code = STATUS_OK;
		if (accept) begin
			unique case (req_opcode)
				OP_PUSH: begin
					cmd.push = !stat.full;
					if (stat.full) code = STATUS_PUSH_FULL;
				end
				OP_POP: begin
					cmd.pop = !stat.empty;
					if (stat.empty) code = STATUS_POP_EMPTY;
				end
				default: begin
					code = STATUS_OK;
				end
			endcase
		end
		if (state_q == S_FILL) cmd.load = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= STATUS_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						status_q <= code;
						state_q  <= cmd.pop ? S_FILL : S_SEND;
					end
				end
				S_FILL: begin
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (rsp_ready) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.push, cmd.pop, cmd.load}))
		else $error("more than one datapath command at once");
	a_pop_refills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> cmd.load)
		else $error("pop not followed by top refill");
	a_rejected_code: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cmd.push && !cmd.pop && (req_opcode == OP_PUSH || req_opcode == OP_POP))
		|=> (status_q != STATUS_OK))
		else $error("ignored operation reported as ok");
`endif

endmodule
`default_nettype wire

>>> hdl/mts_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_dpath: stack datapath
// Holds the top slot in registers and the slots below it in a memory with a
// registered read port, and keeps the running minimum with each slot.
// ----------------------------------------------------------------------------
module mts_dpath
	import mts_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mts_cmd_t                 cmd,
	input  wire logic signed [DATA_W-1:0] push_value,
	output mts_stat_t                     stat,
	output logic signed [DATA_W-1:0]      top_value,
	output logic signed [DATA_W-1:0]      min_value,
	output logic [DEPTH_W-1:0]            depth,
	output logic                          is_empty
);

	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW = $clog2(STACK_DEPTH);

	mts_entry_t mem [STACK_DEPTH];
	mts_entry_t rd_q;
	mts_entry_t top_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic signed [DATA_W-1:0] new_min;
	logic empty;

	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);
	assign empty  = (count_q == '0);

	assign stat.empty = empty;
	assign stat.full  = (count_q == CW'(STACK_DEPTH));

	assign new_min = (!empty && (top_q.rmin < push_value)) ? top_q.rmin : push_value;

	always_ff @(posedge clk) begin
		if (cmd.push && !empty) mem[cnt_m1[AW-1:0]] <= top_q;
		rd_q <= mem[cnt_m2[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q.data <= push_value;
			top_q.rmin <= new_min;
		end else if (cmd.load) begin
			top_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.pop) begin
			count_q <= cnt_m1;
		end
	end

	assign top_value = empty ? '0 : top_q.data;
	assign min_value = empty ? '0 : top_q.rmin;
	assign depth     = DEPTH_W'(count_q);
	assign is_empty  = empty;

`ifndef NO_ASSERTIONS
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not grow the stack");
	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> (count_q == $past(count_q) - CW'(1)))
		else $error("pop did not shrink the stack");
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && stat.full) && !(cmd.pop && stat.empty))
		else $error("operation past a stack bound");
	a_min_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> (top_q.rmin <= top_q.data))
		else $error("running minimum above top entry");
`endif

endmodule
`default_nettype wire
